// ----- hw/rtl/vector_norm_dot_engine_defines.svh -----
// Assertion macros for the vector norm and dot engine checker.
`ifndef VECTOR_NORM_DOT_ENGINE_DEFINES_SVH
`define VECTOR_NORM_DOT_ENGINE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define VND_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define VND_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also holds through reset.
`define VND_ASSERT_RST(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/vnd_pkg.sv -----
// Shared constants, types and helper functions of the vector norm and dot engine.
`default_nettype none

package vnd_pkg;

    localparam int DEF_ELEM_BITS = 32;
    localparam int DEF_FRAC_BITS = 16;

    localparam int OUT_BITS  = 48;
    localparam int ACC_BITS  = 64;
    localparam int ROOT_BITS = ACC_BITS / 2;
    localparam int TOL_BITS  = 32;
    localparam int OP_BITS   = 3;
    localparam int NK_BITS   = 2;

    localparam logic [TOL_BITS-1:0] TOL_RESET = TOL_BITS'(66);

    localparam logic [OP_BITS-1:0] OP_ADD    = 3'd0;
    localparam logic [OP_BITS-1:0] OP_SUB    = 3'd1;
    localparam logic [OP_BITS-1:0] OP_SCALE  = 3'd2;
    localparam logic [OP_BITS-1:0] OP_DOT    = 3'd3;
    localparam logic [OP_BITS-1:0] OP_NORM   = 3'd4;
    localparam logic [OP_BITS-1:0] OP_EQUALS = 3'd5;

    localparam logic [NK_BITS-1:0] NK_L1   = 2'd0;
    localparam logic [NK_BITS-1:0] NK_L2   = 2'd1;
    localparam logic [NK_BITS-1:0] NK_LINF = 2'd2;

    localparam logic [ACC_BITS-1:0] OUT_MAX_U =
        (ACC_BITS'(1) << (OUT_BITS - 1)) - ACC_BITS'(1);
    localparam logic signed [ACC_BITS-1:0] OUT_MAX_S = signed'(OUT_MAX_U);
    localparam logic signed [ACC_BITS-1:0] OUT_MIN_S = -OUT_MAX_S - ACC_BITS'(1);
    localparam logic [ACC_BITS-1:0] PROD_CLAMP = ACC_BITS'(1) << (ACC_BITS - 2);

    typedef struct packed {
        logic signed [OUT_BITS-1:0] val;
        logic                       ovf;
    } t_sat;

    function automatic t_sat sat_out(input logic signed [ACC_BITS-1:0] v);
        t_sat r;
        if (v > OUT_MAX_S) begin
            r.val = OUT_MAX_S[OUT_BITS-1:0];
            r.ovf = 1'b1;
        end else if (v < OUT_MIN_S) begin
            r.val = OUT_MIN_S[OUT_BITS-1:0];
            r.ovf = 1'b1;
        end else begin
            r.val = v[OUT_BITS-1:0];
            r.ovf = 1'b0;
        end
        return r;
    endfunction

    function automatic logic [ACC_BITS-1:0] mag64(input logic signed [ACC_BITS-1:0] v);
        return v[ACC_BITS-1] ? ACC_BITS'(-v) : ACC_BITS'(v);
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/vnd_if.sv -----
// Request and result channel interfaces of the vector norm and dot engine.
`default_nettype none

interface vnd_req_if
    import vnd_pkg::*;
#(
    parameter int ELEM_BITS = DEF_ELEM_BITS
);
    logic                        valid;
    logic                        ready;
    logic [OP_BITS-1:0]          req_type;
    logic [NK_BITS-1:0]          norm_kind;
    logic signed [ELEM_BITS-1:0] elem_a;
    logic signed [ELEM_BITS-1:0] elem_b;
    logic signed [ELEM_BITS-1:0] scale_factor;
    logic                        last_elem;

    modport source (
        output valid, req_type, norm_kind, elem_a, elem_b, scale_factor, last_elem,
        input  ready
    );
    modport sink (
        input  valid, req_type, norm_kind, elem_a, elem_b, scale_factor, last_elem,
        output ready
    );
endinterface

interface vnd_res_if
    import vnd_pkg::*;
;
    logic                       valid;
    logic                       ready;
    logic signed [OUT_BITS-1:0] result_value;
    logic                       equal_flag;
    logic                       saturated;
    logic                       last_result;

    modport source (
        output valid, result_value, equal_flag, saturated, last_result,
        input  ready
    );
    modport sink (
        input  valid, result_value, equal_flag, saturated, last_result,
        output ready
    );
endinterface

`default_nettype wire

// ----- hw/rtl/vector_norm_dot_engine.sv -----
// Streaming vector add, subtract, scale, dot product, norm and equality engine.
//
//  channel   dir  handshake            payload
//  i_req     in   valid/ready          req_type norm_kind elem_a elem_b scale_factor last_elem
//  o_res     out  valid/ready          result_value equal_flag saturated last_result
//  cfg       in   i_cfg_we             i_cfg_wdata (tolerance)
//
// One beat at a time: add/subtract pass straight from the prepare to the finish state; scale,
// dot and L2 elements also wait on the shared three-step multiplier and then fold; L1/L-inf
// elements fold without it. Scale results and the last beat of a vector reach the finish state.
// The last beat of an L2 norm or L2 equality also runs the bit-serial root first.
// Input is taken again once the result sits in the output register; o_res stalls
// only hold the engine when a second result is ready. Reset is synchronous, active low.
`default_nettype none

module vector_norm_dot_engine
    import vnd_pkg::*;
#(
    parameter int ELEM_BITS = DEF_ELEM_BITS,
    parameter int FRAC_BITS = DEF_FRAC_BITS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [TOL_BITS-1:0] i_cfg_wdata,
    vnd_req_if.sink             i_req,
    vnd_res_if.source           o_res
);

    localparam int MW = (ELEM_BITS >= OUT_BITS - 1) ? ELEM_BITS : ELEM_BITS + 1;
    localparam int PW = 2 * MW;
    localparam int XW = 2 * ACC_BITS;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PREP = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_FOLD = 3'd3;
    localparam logic [2:0] S_SQRT = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;

    logic [2:0]            r_state, n_state;
    logic                  r_mid, n_mid;
    logic [OP_BITS-1:0]    r_op, n_op;
    logic [NK_BITS-1:0]    r_kind, n_kind;
    logic [ACC_BITS-1:0]   r_acc, n_acc;
    logic                  r_sticky, n_sticky;
    logic [TOL_BITS-1:0]   r_tol;
    logic                  r_out_valid, n_out_valid;

    logic signed [ELEM_BITS-1:0] r_a, r_b, r_s;
    logic                        r_last;
    logic signed [OUT_BITS-1:0]  r_val, n_val;
    logic                        r_flag, n_flag;
    logic                        r_neg, n_neg;
    logic [MW-1:0]               r_m, n_m;
    logic signed [OUT_BITS-1:0]  r_out_value, n_out_value;
    logic                        r_out_eq, n_out_eq;
    logic                        r_out_sat, n_out_sat;
    logic                        r_out_last, n_out_last;

    logic                  accept;
    logic                  out_free;
    logic signed [ACC_BITS-1:0] a64, b64, s64;
    t_sat                  sum_ab, dif_ab;
    logic [ACC_BITS-1:0]   nm_raw, nm;
    logic                  nm_clamp, nm_flag;
    logic                  is_norm;

    logic                  mul_start, mul_done;
    logic [MW-1:0]         mul_ma, mul_mb;
    logic [PW-1:0]         mul_prod;

    logic [XW-1:0]         prod_ext, q_ext;
    logic [ACC_BITS-1:0]   pm_u;
    logic signed [ACC_BITS-1:0] pm;
    t_sat                  scl, dot;
    logic [ACC_BITS-1:0]   l1_sum;
    logic                  l2_hi, l2_c;
    logic [ACC_BITS-1:0]   l2_sum;

    logic                  sq_start, sq_done;
    logic [ROOT_BITS-1:0]  sq_root;
    logic [OUT_BITS-1:0]   norm_val;

    assign accept   = i_req.valid && i_req.ready;
    assign out_free = !r_out_valid || o_res.ready;
    assign is_norm  = (r_op == OP_NORM) || (r_op == OP_EQUALS);

    assign a64    = ACC_BITS'(r_a);
    assign b64    = ACC_BITS'(r_b);
    assign s64    = ACC_BITS'(r_s);
    assign sum_ab = sat_out(a64 + b64);
    assign dif_ab = sat_out(a64 - b64);

    assign nm_raw   = (r_op == OP_EQUALS) ? mag64(ACC_BITS'(dif_ab.val)) : mag64(a64);
    assign nm_clamp = nm_raw > OUT_MAX_U;
    assign nm       = nm_clamp ? OUT_MAX_U : nm_raw;
    assign nm_flag  = nm_clamp || ((r_op == OP_EQUALS) && dif_ab.ovf);

    assign mul_ma = is_norm ? MW'(nm) : MW'(mag64(a64));
    assign mul_mb = (r_op == OP_SCALE) ? MW'(mag64(s64)) :
                    (r_op == OP_DOT)   ? MW'(mag64(b64)) : MW'(nm);

    assign prod_ext = XW'(mul_prod);
    assign q_ext    = prod_ext >> FRAC_BITS;
    assign pm_u     = (q_ext > XW'(PROD_CLAMP)) ? PROD_CLAMP : q_ext[ACC_BITS-1:0];
    assign pm       = r_neg ? -signed'(pm_u) : signed'(pm_u);
    assign scl      = sat_out(pm);
    assign dot      = sat_out(signed'(r_acc) + pm);
    assign l1_sum   = r_acc + ACC_BITS'(r_m);
    assign l2_hi    = |prod_ext[XW-1:ACC_BITS];
    assign {l2_c, l2_sum} = (ACC_BITS + 1)'(r_acc) + (ACC_BITS + 1)'(prod_ext[ACC_BITS-1:0]);

    assign norm_val = (r_kind == NK_L2) ? OUT_BITS'(sq_root) : r_acc[OUT_BITS-1:0];

    always_comb begin
        n_state     = r_state;
        n_mid       = r_mid;
        n_op        = r_op;
        n_kind      = r_kind;
        n_acc       = r_acc;
        n_sticky    = r_sticky;
        n_out_valid = r_out_valid;
        n_val       = r_val;
        n_flag      = r_flag;
        n_neg       = r_neg;
        n_m         = r_m;
        n_out_value = r_out_value;
        n_out_eq    = r_out_eq;
        n_out_sat   = r_out_sat;
        n_out_last  = r_out_last;
        mul_start   = 1'b0;
        sq_start    = 1'b0;

        if (r_out_valid && o_res.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_mid = !i_req.last_elem;
                    if (!r_mid) begin
                        n_op     = i_req.req_type;
                        n_kind   = i_req.norm_kind;
                        n_acc    = '0;
                        n_sticky = 1'b0;
                    end
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                n_neg = r_a[ELEM_BITS-1] ^
                        ((r_op == OP_SCALE) ? r_s[ELEM_BITS-1] : r_b[ELEM_BITS-1]);
                n_m   = MW'(nm);
                unique case (r_op)
                    OP_ADD: begin
                        n_val   = sum_ab.val;
                        n_flag  = sum_ab.ovf;
                        n_state = S_FIN;
                    end
                    OP_SUB: begin
                        n_val   = dif_ab.val;
                        n_flag  = dif_ab.ovf;
                        n_state = S_FIN;
                    end
                    OP_SCALE, OP_DOT: begin
                        mul_start = 1'b1;
                        n_state   = S_MUL;
                    end
                    OP_NORM, OP_EQUALS: begin
                        n_sticky = r_sticky || nm_flag;
                        if (r_kind == NK_L2) begin
                            mul_start = 1'b1;
                            n_state   = S_MUL;
                        end else begin
                            n_state = S_FOLD;
                        end
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_MUL: begin
                if (mul_done) begin
                    n_state = S_FOLD;
                end
            end
            S_FOLD: begin
                n_state = S_IDLE;
                unique case (r_op)
                    OP_SCALE: begin
                        n_val   = scl.val;
                        n_flag  = scl.ovf;
                        n_state = S_FIN;
                    end
                    OP_DOT: begin
                        n_acc    = ACC_BITS'(dot.val);
                        n_sticky = r_sticky || dot.ovf;
                        n_val    = dot.val;
                        if (r_last) begin
                            n_state = S_FIN;
                        end
                    end
                    OP_NORM, OP_EQUALS: begin
                        priority if (r_kind == NK_L1) begin
                            if (l1_sum > OUT_MAX_U) begin
                                n_acc    = OUT_MAX_U;
                                n_sticky = 1'b1;
                            end else begin
                                n_acc = l1_sum;
                            end
                        end else if (r_kind == NK_L2) begin
                            if (l2_hi || l2_c) begin
                                n_acc    = '1;
                                n_sticky = 1'b1;
                            end else begin
                                n_acc = l2_sum;
                            end
                        end else begin
                            if (ACC_BITS'(r_m) > r_acc) begin
                                n_acc = ACC_BITS'(r_m);
                            end
                        end
                        if (r_last) begin
                            if (r_kind == NK_L2) begin
                                sq_start = 1'b1;
                                n_state  = S_SQRT;
                            end else begin
                                n_state = S_FIN;
                            end
                        end
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_SQRT: begin
                if (sq_done) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_last  = r_last;
                    n_out_eq    = 1'b0;
                    if (is_norm) begin
                        n_out_value = signed'(norm_val);
                        n_out_sat   = r_sticky;
                        n_out_eq    = (r_op == OP_EQUALS) &&
                                      (ACC_BITS'(norm_val) < ACC_BITS'(r_tol));
                        n_out_last  = 1'b1;
                    end else if (r_op == OP_DOT) begin
                        n_out_value = r_val;
                        n_out_sat   = r_sticky;
                        n_out_last  = 1'b1;
                    end else begin
                        n_out_value = r_val;
                        n_out_sat   = r_flag;
                    end
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mid       <= 1'b0;
            r_op        <= OP_ADD;
            r_kind      <= NK_L1;
            r_acc       <= '0;
            r_sticky    <= 1'b0;
            r_tol       <= TOL_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_mid       <= n_mid;
            r_op        <= n_op;
            r_kind      <= n_kind;
            r_acc       <= n_acc;
            r_sticky    <= n_sticky;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_tol <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a    <= i_req.elem_a;
            r_b    <= i_req.elem_b;
            r_s    <= i_req.scale_factor;
            r_last <= i_req.last_elem;
        end
        r_val       <= n_val;
        r_flag      <= n_flag;
        r_neg       <= n_neg;
        r_m         <= n_m;
        r_out_value <= n_out_value;
        r_out_eq    <= n_out_eq;
        r_out_sat   <= n_out_sat;
        r_out_last  <= n_out_last;
    end

    vnd_mul #(
        .MW (MW)
    ) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_ma    (mul_ma),
        .i_mb    (mul_mb),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    vnd_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_value (n_acc),
        .o_done  (sq_done),
        .o_root  (sq_root)
    );

    assign i_req.ready        = (r_state == S_IDLE);
    assign o_res.valid        = r_out_valid;
    assign o_res.result_value = r_out_value;
    assign o_res.equal_flag   = r_out_eq;
    assign o_res.saturated    = r_out_sat;
    assign o_res.last_result  = r_out_last;

endmodule

`default_nettype wire

// ----- hw/rtl/vnd_mul.sv -----
// Shared unsigned multiplier: two half-width partial products summed over the low, high and sum steps.
`default_nettype none

module vnd_mul
    import vnd_pkg::*;
#(
    parameter int MW = DEF_ELEM_BITS + 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [MW-1:0]     i_ma,
    input  logic [MW-1:0]     i_mb,
    output logic              o_done,
    output logic [2*MW-1:0]   o_prod
);

    localparam int H  = (MW + 1) / 2;
    localparam int PP = MW + H;

    localparam logic [1:0] ST_LO  = 2'd0;
    localparam logic [1:0] ST_HI  = 2'd1;
    localparam logic [1:0] ST_SUM = 2'd2;

    logic [MW-1:0]   r_ma;
    logic [MW-1:0]   r_mb;
    logic [1:0]      r_step;
    logic            r_busy;
    logic            r_done;
    logic [PP-1:0]   r_pp;
    logic [2*MW-1:0] r_prod;

    logic [H-1:0]    mul_b;
    logic [PP-1:0]   pp_n;

    assign mul_b = (r_step == ST_LO) ? r_mb[H-1:0] : H'(r_mb[MW-1:H]);
    assign pp_n  = PP'(r_ma) * PP'(mul_b);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= ST_LO;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= ST_LO;
            end else if (r_busy) begin
                unique case (r_step)
                    ST_LO:   r_step <= ST_HI;
                    ST_HI:   r_step <= ST_SUM;
                    default: begin
                        r_step <= ST_LO;
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_ma <= i_ma;
            r_mb <= i_mb;
        end else if (r_busy) begin
            unique case (r_step)
                ST_LO: r_pp <= pp_n;
                ST_HI: begin
                    r_prod <= (2*MW)'(r_pp);
                    r_pp   <= pp_n;
                end
                default: r_prod <= r_prod + ((2*MW)'(r_pp) << H);
            endcase
        end
    end

    assign o_done = r_done;
    assign o_prod = r_prod;

endmodule

`default_nettype wire

// ----- hw/rtl/vnd_isqrt.sv -----
// Iterative floor square root of a 64-bit value, one result bit per cycle.
`default_nettype none

module vnd_isqrt
    import vnd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [ACC_BITS-1:0]  i_value,
    output logic                 o_done,
    output logic [ROOT_BITS-1:0] o_root
);

    logic                r_busy;
    logic                r_done;
    logic [ACC_BITS-1:0] r_rem;
    logic [ACC_BITS-1:0] r_work;
    logic [ACC_BITS-1:0] r_bit;

    logic [ACC_BITS-1:0] trial;
    logic                take;

    assign trial = r_work + r_bit;
    assign take  = (r_rem >= trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_bit[0]) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_value;
            r_work <= '0;
            r_bit  <= ACC_BITS'(1) << (ACC_BITS - 2);
        end else if (r_busy) begin
            if (take) begin
                r_rem  <= r_rem - trial;
                r_work <= (r_work >> 1) + r_bit;
            end else begin
                r_work <= r_work >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    assign o_done = r_done;
    assign o_root = r_work[ROOT_BITS-1:0];

endmodule

`default_nettype wire

// ----- hw/rtl/vnd_chk.sv -----
// Port-level assertion checker for the vector norm and dot engine, with its bind.
`default_nettype none

`include "vector_norm_dot_engine_defines.svh"

module vnd_chk (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_req_valid,
    input logic i_req_ready,
    input logic i_res_valid,
    input logic i_res_ready,
    input logic i_res_eq,
    input logic i_res_last
);

    `VND_ASSERT_NEXT(a_res_hold, i_res_valid && !i_res_ready, i_res_valid, "result beat dropped")
    `VND_ASSERT_NEXT(a_one_beat, i_req_valid && i_req_ready, !i_req_ready, "beat taken while busy")
    `VND_ASSERT_NOW(a_eq_last, i_res_valid && i_res_eq, i_res_last, "equal flag off last result")
    `VND_ASSERT_RST(a_rst_idle, !i_rst_n, !i_res_valid && i_req_ready, "not idle after reset")

endmodule

bind vector_norm_dot_engine vnd_chk u_vnd_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_res_valid (o_res.valid),
    .i_res_ready (o_res.ready),
    .i_res_eq    (o_res.equal_flag),
    .i_res_last  (o_res.last_result)
);

`default_nettype wire
